// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the translation buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define TLBF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Same, with a caller message.
`define TLBF_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

// ===== rtl/tlbf_pkg.sv =====
// Shared constants, types and helpers for the translation buffer.
`default_nettype none

package tlbf_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int IDX_W       = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int PAGE_W      = 20;
  localparam int FRAME_W     = 20;
  localparam int CFG_W       = 5;
  localparam int HITS_W      = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef logic [TLB_ENTRIES-1:0] entry_mask_t;
  typedef logic [IDX_W-1:0]       entry_idx_t;

  typedef struct packed {
    logic capture;  // latch the incoming word
    logic commit;   // run lookup / fill and load the result register
  } tlbf_cmd_t;

  typedef struct packed {
    logic out_valid;
  } tlbf_status_t;

  // Keep only the lowest set bit.
  function automatic entry_mask_t first_one(input entry_mask_t mask);
    return mask & (~mask + entry_mask_t'(1));
  endfunction

  function automatic entry_idx_t onehot_idx(input entry_mask_t oh);
    entry_idx_t idx;
    idx = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (oh[i]) begin
        idx = idx | entry_idx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tlbf_ctrl.sv =====
// Controller for the translation buffer: capture and lookup sequencing.
`default_nettype none

module tlbf_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  out_ready,
  input  wire tlbf_pkg::tlbf_status_t status,
  output tlbf_pkg::tlbf_cmd_t        cmd
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_LOOK
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  // Commit only when the result register is free or drains this cycle.
  assign cmd.commit  = (state_r == S_LOOK) && (!status.out_valid || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tlbf_datapath.sv =====
// Datapath for the translation buffer: entries, compare, victim pick, result register.
`default_nettype none

module tlbf_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tlbf_pkg::tlbf_cmd_t                 cmd,
  output tlbf_pkg::tlbf_status_t                   status,
  input  wire logic [tlbf_pkg::PAGE_W-1:0]         in_page_number,
  input  wire logic                                in_is_write,
  input  wire logic [tlbf_pkg::FRAME_W-1:0]        in_walk_frame,
  input  wire logic                                out_ready,
  output logic [tlbf_pkg::FRAME_W-1:0]             out_frame,
  output logic                                     out_hit,
  output logic [tlbf_pkg::HITS_W-1:0]              out_hits_so_far,
  input  wire logic                                cfg_valid,
  input  wire logic [tlbf_pkg::CFG_W-1:0]          cfg_entries_in_use
);

  logic [tlbf_pkg::PAGE_W-1:0]  entry_page_r  [tlbf_pkg::TLB_ENTRIES];
  logic [tlbf_pkg::FRAME_W-1:0] entry_frame_r [tlbf_pkg::TLB_ENTRIES];
  tlbf_pkg::entry_mask_t        valid_r;
  tlbf_pkg::entry_mask_t        dirty_r;
  tlbf_pkg::entry_mask_t        used_r;

  logic [tlbf_pkg::CFG_W-1:0]   cfg_r;
  logic [tlbf_pkg::HITS_W-1:0]  hit_cnt_r;
  logic [tlbf_pkg::HITS_W-1:0]  hit_cnt_nxt;

  logic [tlbf_pkg::PAGE_W-1:0]  req_page_r;
  logic                         req_write_r;
  logic [tlbf_pkg::FRAME_W-1:0] req_walk_r;

  logic                         out_valid_r;
  logic [tlbf_pkg::FRAME_W-1:0] out_frame_r;
  logic                         out_hit_r;
  logic [tlbf_pkg::HITS_W-1:0]  out_hits_r;

  tlbf_pkg::entry_mask_t        active;
  tlbf_pkg::entry_mask_t        match;
  tlbf_pkg::entry_mask_t        invalid_m;
  tlbf_pkg::entry_mask_t        unused_m;
  logic                         hit_any;
  tlbf_pkg::entry_idx_t         hit_idx;
  tlbf_pkg::entry_idx_t         victim_idx;

  // Entries at or beyond the programmed count are not searched, and not replaced except entry 0 when the count is zero.
  always_comb begin
    for (int i = 0; i < tlbf_pkg::TLB_ENTRIES; i++) begin
      active[i] = (32'(i) < 32'(cfg_r));
      match[i]  = valid_r[i] && active[i] && (entry_page_r[i] == req_page_r);
    end
  end

  assign invalid_m   = ~valid_r & active;
  assign unused_m    = ~used_r & active;
  assign hit_any     = |match;
  assign hit_idx     = tlbf_pkg::onehot_idx(tlbf_pkg::first_one(match));
  assign hit_cnt_nxt = hit_cnt_r + tlbf_pkg::HITS_W'(1);

  // First invalid, then first unused, else entry 0.
  always_comb begin
    priority if (|invalid_m) begin
      victim_idx = tlbf_pkg::onehot_idx(tlbf_pkg::first_one(invalid_m));
    end else if (|unused_m) begin
      victim_idx = tlbf_pkg::onehot_idx(tlbf_pkg::first_one(unused_m));
    end else begin
      victim_idx = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      dirty_r     <= '0;
      used_r      <= '0;
      hit_cnt_r   <= '0;
      cfg_r       <= tlbf_pkg::CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_entries_in_use;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (hit_any) begin
          dirty_r[hit_idx] <= req_write_r;
          hit_cnt_r        <= hit_cnt_nxt;
        end else begin
          valid_r[victim_idx] <= 1'b1;
          dirty_r[victim_idx] <= req_write_r;
          used_r[victim_idx]  <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: request latch, entry contents, result word.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_page_r  <= in_page_number;
      req_write_r <= in_is_write;
      req_walk_r  <= in_walk_frame;
    end
    if (cmd.commit) begin
      if (hit_any) begin
        out_frame_r <= entry_frame_r[hit_idx];
        out_hit_r   <= 1'b1;
        out_hits_r  <= hit_cnt_nxt;
      end else begin
        entry_page_r[victim_idx]  <= req_page_r;
        entry_frame_r[victim_idx] <= req_walk_r;
        out_frame_r               <= req_walk_r;
        out_hit_r                 <= 1'b0;
        out_hits_r                <= hit_cnt_r;
      end
    end
  end

  assign status.out_valid = out_valid_r;
  assign out_frame        = out_frame_r;
  assign out_hit          = out_hit_r;
  assign out_hits_so_far  = out_hits_r;

endmodule

`default_nettype wire

// ===== rtl/tlb_lookup_with_fill_core.sv =====
// Fully associative translation buffer with fill on miss: lookup, victim pick, hit counter.
// Each word is first latched in the request register; then, in the lookup state, all active
// entries are compared in parallel, the first match (or the victim, chosen as first invalid,
// then first unused, else entry 0) is picked by priority encoders, the entry is updated and
// the result is loaded into the output register. The lookup waits only while the
// previous result is still held unclaimed; a new request is taken while a result waits.
// Valid marks are flip-flops cleared by reset, so the block is usable right after reset.
// The entry count register (reset 16) may only be written while the block is idle.
`default_nettype none

`include "assert_macros.svh"

module tlb_lookup_with_fill_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [tlbf_pkg::PAGE_W-1:0]  in_page_number,
  input  wire logic                         in_is_write,
  input  wire logic [tlbf_pkg::FRAME_W-1:0] in_walk_frame,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tlbf_pkg::FRAME_W-1:0]      out_frame,
  output logic                              out_hit,
  output logic [tlbf_pkg::HITS_W-1:0]       out_hits_so_far,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [tlbf_pkg::CFG_W-1:0]   cfg_entries_in_use
);

  tlbf_pkg::tlbf_cmd_t    cmd;
  tlbf_pkg::tlbf_status_t status;

  assign cfg_ready = 1'b1;
  assign out_valid = status.out_valid;

  tlbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tlbf_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_page_number     (in_page_number),
    .in_is_write        (in_is_write),
    .in_walk_frame      (in_walk_frame),
    .out_ready          (out_ready),
    .out_frame          (out_frame),
    .out_hit            (out_hit),
    .out_hits_so_far    (out_hits_so_far),
    .cfg_valid          (cfg_valid),
    .cfg_entries_in_use (cfg_entries_in_use)
  );

  `TLBF_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  `TLBF_ASSERT(a_commit_loads_result, clk, rst_n, cmd.commit |=> out_valid)
  `TLBF_ASSERT_MSG(a_result_from_commit, clk, rst_n, $rose(out_valid) |-> $past(cmd.commit),
                   "result appeared without a lookup")

endmodule

`default_nettype wire

// ===== sim/tlb_xlat_checker.sv =====
// Translation buffer checker: shadow entry table, expected-result queue and field compare.
module tlb_xlat_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [tlbf_pkg::PAGE_W-1:0]  in_page_number,
  input  logic                         in_is_write,
  input  logic [tlbf_pkg::FRAME_W-1:0] in_walk_frame,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [tlbf_pkg::FRAME_W-1:0] out_frame,
  input  logic                         out_hit,
  input  logic [tlbf_pkg::HITS_W-1:0]  out_hits_so_far,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [tlbf_pkg::CFG_W-1:0]   cfg_entries_in_use,
  output int unsigned                  mismatch_count,
  output int unsigned                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlbf_pkg::*;

  localparam int PRINT_CAP = 60;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               hit;
    logic [HITS_W-1:0]  hits_so_far;
  } xlat_result_t;

  logic [PAGE_W-1:0]  shadow_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0] shadow_frame [TLB_ENTRIES];
  bit                 shadow_valid [TLB_ENTRIES];
  bit                 shadow_dirty [TLB_ENTRIES];
  bit                 shadow_used  [TLB_ENTRIES];
  logic [HITS_W-1:0]  shadow_hits;
  logic [CFG_W-1:0]   shadow_count;
  xlat_result_t       expected_xlat [$];

  task automatic report_mismatch(input string what, input logic [HITS_W-1:0] got,
                                 input logic [HITS_W-1:0] want);
    // keep the log short when everything goes wrong
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic xlat_result_t translate_access(input logic [PAGE_W-1:0] page,
                                                    input logic wr,
                                                    input logic [FRAME_W-1:0] walk);
    xlat_result_t res;
    int           n;
    int           victim;
    bit           found;
    n = (shadow_count > CFG_W'(TLB_ENTRIES)) ? TLB_ENTRIES : int'(shadow_count);
    for (int i = 0; i < n; i++) begin
      if (shadow_valid[i] && shadow_page[i] == page) begin
        shadow_dirty[i] = wr;
        shadow_hits     = shadow_hits + 1'b1;
        res.frame       = shadow_frame[i];
        res.hit         = 1'b1;
        res.hits_so_far = shadow_hits;
        return res;
      end
    end
    // victim: first invalid, then first unused, else entry 0
    victim = 0;
    found  = 1'b0;
    for (int i = 0; i < n && !found; i++) begin
      if (!shadow_valid[i]) begin
        victim = i;
        found  = 1'b1;
      end
    end
    for (int i = 0; i < n && !found; i++) begin
      if (!shadow_used[i]) begin
        victim = i;
        found  = 1'b1;
      end
    end
    shadow_page[victim]  = page;
    shadow_frame[victim] = walk;
    shadow_valid[victim] = 1'b1;
    shadow_dirty[victim] = wr;
    shadow_used[victim]  = 1'b1;
    res.frame       = walk;
    res.hit         = 1'b0;
    res.hits_so_far = shadow_hits;
    return res;
  endfunction

  always @(posedge clk) begin
    xlat_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        shadow_valid[i] = 1'b0;
        shadow_dirty[i] = 1'b0;
        shadow_used[i]  = 1'b0;
      end
      shadow_hits  = '0;
      shadow_count = CFG_RESET;
      expected_xlat.delete();
      mismatch_count = 0;
    end else begin
      // retire the result first: it always belongs to an earlier word
      if (out_valid && out_ready) begin
        if (expected_xlat.size() == 0) begin
          report_mismatch("result word with nothing pending", HITS_W'(out_frame), '0);
        end else begin
          want = expected_xlat.pop_front();
          if (out_frame !== want.frame) begin
            report_mismatch("frame", HITS_W'(out_frame), HITS_W'(want.frame));
          end
          if (out_hit !== want.hit) begin
            report_mismatch("hit", HITS_W'(out_hit), HITS_W'(want.hit));
          end
          if (out_hits_so_far !== want.hits_so_far) begin
            report_mismatch("hits_so_far", out_hits_so_far, want.hits_so_far);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        shadow_count = cfg_entries_in_use;
      end
      if (in_valid && in_ready) begin
        expected_xlat.push_back(translate_access(in_page_number, in_is_write, in_walk_frame));
      end
    end
    pending = expected_xlat.size();
  end

endmodule

// ===== sim/tlb_lookup_with_fill_core_tb.sv =====
// Testbench top for the translation buffer: clock, reset, stimulus, watchdog and verdict.
module tlb_lookup_with_fill_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlbf_pkg::*;

  localparam int ITEMS_PER_PHASE = 216;
  localparam int HOT_PAGES       = 20;
  localparam int QUIET_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 8;
  localparam int NUM_PHASES      = 8;

  logic               clk                = 1'b0;
  logic               rst_n              = 1'b0;
  logic               in_valid           = 1'b0;
  logic               in_ready;
  logic [PAGE_W-1:0]  in_page_number     = '0;
  logic               in_is_write        = 1'b0;
  logic [FRAME_W-1:0] in_walk_frame      = '0;
  logic               out_valid;
  logic               out_ready          = 1'b0;
  logic [FRAME_W-1:0] out_frame;
  logic               out_hit;
  logic [HITS_W-1:0]  out_hits_so_far;
  logic               cfg_valid          = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_entries_in_use = CFG_RESET;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;

  logic [PAGE_W-1:0] hot_pages [HOT_PAGES];
  logic [CFG_W-1:0]  phase_counts [NUM_PHASES] =
    '{5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'd16, 5'd9, 5'd16};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tlb_lookup_with_fill_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_page_number     (in_page_number),
    .in_is_write        (in_is_write),
    .in_walk_frame      (in_walk_frame),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame          (out_frame),
    .out_hit            (out_hit),
    .out_hits_so_far    (out_hits_so_far),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_entries_in_use (cfg_entries_in_use)
  );

  tlb_xlat_checker xlat_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_page_number     (in_page_number),
    .in_is_write        (in_is_write),
    .in_walk_frame      (in_walk_frame),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame          (out_frame),
    .out_hit            (out_hit),
    .out_hits_so_far    (out_hits_so_far),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_entries_in_use (cfg_entries_in_use),
    .mismatch_count     (mismatch_count),
    .pending            (pending)
  );

  always @(negedge clk) begin
    out_ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
  end

  // End the run if no channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [PAGE_W-1:0] page, input logic wr,
                           input logic [FRAME_W-1:0] walk);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_page_number <= page;
    in_is_write    <= wr;
    in_walk_frame  <= walk;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    cfg_valid          <= 1'b1;
    cfg_entries_in_use <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [PAGE_W-1:0] page;
    int unsigned       span;
    int unsigned       roll;
    int unsigned       idx;
    hot_pages[0] = '0;
    hot_pages[1] = '1;
    for (int i = 2; i < HOT_PAGES; i++) begin
      hot_pages[i] = PAGE_W'($urandom);
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, dirty update on hit, full table, replacement of entry 0.
    send_word('0, 1'b0, '0);
    send_word('0, 1'b1, 20'hABCDE);
    send_word('1, 1'b1, '1);
    send_word('1, 1'b0, '0);
    for (int i = 0; i < 14; i++) begin
      send_word(PAGE_W'(20'h00100 + i), i[0], FRAME_W'($urandom));
    end
    send_word(20'h55555, 1'b0, 20'h12345);
    send_word(20'h55555, 1'b1, 20'h0);
    send_word('0, 1'b1, 20'hFEDCB);
    send_word('1, 1'b1, 20'h0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clk);
      write_count(phase_counts[p]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      span = ((phase_counts[p] > CFG_W'(TLB_ENTRIES)) ? TLB_ENTRIES
                                                      : phase_counts[p]) + 4;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // hold off until the buffer has drained once per phase
        if (k == ITEMS_PER_PHASE / 2) begin
          wait_idle();
        end
        roll = $urandom_range(0, 99);
        idx  = $urandom_range(0, span - 1);
        if (roll < 70) begin
          page = hot_pages[idx];
        end else if (roll < 85) begin
          page = hot_pages[idx] ^ (PAGE_W'(1) << $urandom_range(0, PAGE_W - 1));
        end else begin
          page = PAGE_W'($urandom);
        end
        send_word(page, 1'($urandom_range(0, 1)), FRAME_W'($urandom));
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
